@@ rtl/utf8_code_point_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_defines: assertion macros
// Check macros for the UTF-8 decoder; empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef UTF8_CODE_POINT_DECODER_DEFINES_SVH
`define UTF8_CODE_POINT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define U8CPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define U8CPD_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define U8CPD_ASSERT(lbl, prop, msg)
`define U8CPD_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ rtl/u8cpd_pkg.sv @@
// ----------------------------------------------------------------------------
// u8cpd_pkg: shared types and constants
// Sequence state, result job and lead-byte classification for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8cpd_pkg;

	localparam int unsigned CpW = 21;

	localparam logic [CpW-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CpW-1:0] CP_MAX         = 21'h10FFFF;
	localparam logic [CpW-1:0] CP_SURR_LO     = 21'h00D800;
	localparam logic [CpW-1:0] CP_SURR_HI     = 21'h00DFFF;
	localparam logic [CpW-1:0] CP_MIN_TWO     = 21'h000080;
	localparam logic [CpW-1:0] CP_MIN_THREE   = 21'h000800;
	localparam logic [CpW-1:0] CP_MIN_FOUR    = 21'h010000;

	// lead byte classes
	localparam logic [2:0] LEAD_ASCII   = 3'd0;
	localparam logic [2:0] LEAD_TWO     = 3'd1;
	localparam logic [2:0] LEAD_THREE   = 3'd2;
	localparam logic [2:0] LEAD_FOUR    = 3'd3;
	localparam logic [2:0] LEAD_INVALID = 3'd4;

	typedef struct packed {
		logic           open;
		logic [1:0]     expected;
		logic [1:0]     seen;
		logic [CpW-1:0] pv;
	} seq_state_t;

	localparam seq_state_t SEQ_IDLE = '{open: 1'b0, expected: 2'd0, seen: 2'd0, pv: '0};

	// results of one word: count-1 replacements, then last_cp
	typedef struct packed {
		logic [2:0]     count;
		logic [CpW-1:0] last_cp;
		logic           fin;
	} job_t;

	function automatic logic [2:0] lead_class(input logic [7:0] b);
		logic [2:0] cls;
		if (b[7] == 1'b0)
			cls = LEAD_ASCII;
		else if (b[7:5] == 3'b110)
			cls = LEAD_TWO;
		else if (b[7:4] == 4'b1110)
			cls = LEAD_THREE;
		else if (b[7:3] == 5'b11110)
			cls = LEAD_FOUR;
		else
			cls = LEAD_INVALID;
		return cls;
	endfunction

	function automatic logic [CpW-1:0] min_value(input logic [1:0] expected);
		logic [CpW-1:0] m;
		case (expected)
			2'd1:    m = CP_MIN_TWO;
			2'd2:    m = CP_MIN_THREE;
			default: m = CP_MIN_FOUR;
		endcase
		return m;
	endfunction

endpackage

`default_nettype wire

@@ rtl/u8cpd_byte_if.sv @@
// ----------------------------------------------------------------------------
// u8cpd_byte_if: byte channel
// Valid/ready channel carrying one UTF-8 byte and an end-of-text flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8cpd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/u8cpd_cp_if.sv @@
// ----------------------------------------------------------------------------
// u8cpd_cp_if: code point channel
// Valid/ready channel carrying one decoded code point with its markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface u8cpd_cp_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic        run_last;
	logic        text_end;

	modport source (output valid, output code_point, output run_last, output text_end,
		input ready);
	modport sink   (input valid, input code_point, input run_last, input text_end,
		output ready);
endinterface

`default_nettype wire

@@ rtl/utf8_code_point_decoder.sv @@
// A byte is registered in stage 1; its results are registered in stage 2.
// Throughput: one byte per cycle while the output is ready and each byte
//   yields at most one code point; a byte yielding several (up to 4) code points
//   holds the result register until all are taken, and so can stall the input.
// Reset (arst_n low, asynchronous) empties both stages and closes any sequence.
// ----------------------------------------------------------------------------
// utf8_code_point_decoder: streaming UTF-8 decoder
// Turns UTF-8 bytes into Unicode scalar values, with U+FFFD per bad byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "utf8_code_point_decoder_defines.svh"

module utf8_code_point_decoder (
	input  logic            clk,
	input  logic            arst_n,
	u8cpd_byte_if.sink      text,
	u8cpd_cp_if.source      points
);
	import u8cpd_pkg::*;

	// stage 1: input word register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       fin_s1;

	// pending multi-byte sequence
	seq_state_t state_q;
	seq_state_t state_next;
	job_t       job;

	// stage 2: result job; rem_s2 counts results still to deliver
	logic           valid_s2;
	logic [2:0]     rem_s2;
	logic [CpW-1:0] last_cp_s2;
	logic           fin_s2;

	logic s2_free;
	logic s1_take;
	logic text_take;

	u8cpd_decode u_decode (
		.state      (state_q),
		.data_byte  (byte_s1),
		.final_byte (fin_s1),
		.state_next (state_next),
		.job        (job)
	);

	// Stage 2 frees up when empty or when its last result leaves now.
	assign s2_free   = !valid_s2 || (points.ready && (rem_s2 == 3'd1));
	// A word with no result retires without touching stage 2.
	assign s1_take   = valid_s1 && ((job.count == 3'd0) || s2_free);
	assign text.ready = !valid_s1 || s1_take;
	assign text_take = text.valid && text.ready;

	// Load the input word; drop it once decoded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_take) begin
			byte_s1 <= text.data_byte;
			fin_s1  <= text.final_byte;
		end
	end

	// Advance the sequence state as each word retires.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else if (s1_take) begin
			state_q <= state_next;
		end
	end

	// Hold the job until every result is taken; count down on each handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			rem_s2   <= 3'd0;
		end else if (s1_take && (job.count != 3'd0)) begin
			valid_s2 <= 1'b1;
			rem_s2   <= job.count;
		end else if (valid_s2 && points.ready) begin
			if (rem_s2 == 3'd1) begin
				valid_s2 <= 1'b0;
				rem_s2   <= 3'd0;
			end else begin
				rem_s2 <= rem_s2 - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take && (job.count != 3'd0)) begin
			last_cp_s2 <= job.last_cp;
			fin_s2     <= job.fin;
		end
	end

	// Every result but the last of a word is a replacement.
	assign points.valid      = valid_s2;
	assign points.code_point = (rem_s2 == 3'd1) ? last_cp_s2 : CP_REPLACEMENT;
	assign points.run_last   = (rem_s2 == 3'd1);
	assign points.text_end   = (rem_s2 == 3'd1) && fin_s2;

	`U8CPD_ASSERT(a_rem_range, valid_s2 |-> ((rem_s2 != 3'd0) && (rem_s2 <= 3'd4)), "result count out of range")
	`U8CPD_ASSERT(a_open_shape, state_q.open |-> ((state_q.expected != 2'd0) && (state_q.seen < state_q.expected)), "pending sequence inconsistent")
	`U8CPD_ASSERT(a_closed_clear, !state_q.open |-> ((state_q.pv == '0) && (state_q.seen == 2'd0) && (state_q.expected == 2'd0)), "closed sequence not cleared")
	`U8CPD_ASSERT_NEXT(a_countdown, valid_s2 && points.ready && (rem_s2 != 3'd1), valid_s2 && (rem_s2 == $past(rem_s2) - 3'd1), "result count did not step down")
	`U8CPD_ASSERT(a_no_take_busy, (valid_s1 && !s1_take) |-> !text.ready, "input taken while stage 1 stalled")

endmodule

`default_nettype wire

@@ rtl/u8cpd_decode.sv @@
// ----------------------------------------------------------------------------
// u8cpd_decode: single-byte decode step
// Next sequence state and the result job for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module u8cpd_decode (
	input  u8cpd_pkg::seq_state_t state,
	input  logic [7:0]            data_byte,
	input  logic                  final_byte,
	output u8cpd_pkg::seq_state_t state_next,
	output u8cpd_pkg::job_t       job
);
	import u8cpd_pkg::*;

	logic           cont;
	logic [CpW-1:0] pv_shift;
	logic [1:0]     seen_inc;
	logic           bad;
	logic [2:0]     n0;

	assign cont     = (data_byte[7:6] == 2'b10);
	assign pv_shift = {state.pv[CpW-7:0], data_byte[5:0]};
	assign seen_inc = state.seen + 2'd1;
	assign bad      = (pv_shift < min_value(state.expected)) || (pv_shift > CP_MAX)
		|| ((pv_shift >= CP_SURR_LO) && (pv_shift <= CP_SURR_HI));

	always_comb begin
		state_next  = state;
		job.count   = 3'd0;
		job.last_cp = CP_REPLACEMENT;
		job.fin     = final_byte;
		n0          = 3'd0;
		if (state.open && cont) begin
			if (seen_inc >= state.expected) begin
				state_next = SEQ_IDLE;
				if (bad) begin
					job.count = {1'b0, state.expected} + 3'd1;
				end else begin
					job.count   = 3'd1;
					job.last_cp = pv_shift;
				end
			end else begin
				state_next.pv   = pv_shift;
				state_next.seen = seen_inc;
				if (final_byte) begin
					// flush the cut-off sequence
					state_next = SEQ_IDLE;
					job.count  = {1'b0, seen_inc} + 3'd1;
				end
			end
		end else begin
			// no sequence, or a broken one: one replacement per byte held, then restart
			if (state.open)
				n0 = {1'b0, state.seen} + 3'd1;
			state_next = SEQ_IDLE;
			case (lead_class(data_byte))
				LEAD_ASCII: begin
					job.count   = n0 + 3'd1;
					job.last_cp = {13'd0, data_byte};
				end
				LEAD_TWO, LEAD_THREE, LEAD_FOUR: begin
					if (final_byte) begin
						job.count = n0 + 3'd1;
					end else begin
						job.count       = n0;
						state_next.open = 1'b1;
						state_next.seen = 2'd0;
						case (lead_class(data_byte))
							LEAD_TWO: begin
								state_next.expected = 2'd1;
								state_next.pv       = {16'd0, data_byte[4:0]};
							end
							LEAD_THREE: begin
								state_next.expected = 2'd2;
								state_next.pv       = {17'd0, data_byte[3:0]};
							end
							default: begin
								state_next.expected = 2'd3;
								state_next.pv       = {18'd0, data_byte[2:0]};
							end
						endcase
					end
				end
				default: begin
					job.count = n0 + 3'd1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire
